### rtl/slas_pkg.sv
package slas_pkg;

    typedef enum logic [3:0] {
        ACT_ADDL   = 4'd0,
        ACT_SUBL   = 4'd1,
        ACT_ADDW   = 4'd2,
        ACT_SUBW   = 4'd3,
        ACT_ADDHN  = 4'd4,
        ACT_RADDHN = 4'd5,
        ACT_SUBHN  = 4'd6,
        ACT_RSUBHN = 4'd7,
        ACT_HADD   = 4'd8,
        ACT_RHADD  = 4'd9,
        ACT_HSUB   = 4'd10,
        ACT_PADD   = 4'd11,
        ACT_PADDL  = 4'd12,
        ACT_PADAL  = 4'd13
    } action_t;

    localparam logic [1:0] LS_8  = 2'd0;
    localparam logic [1:0] LS_16 = 2'd1;
    localparam logic [1:0] LS_32 = 2'd2;

    typedef struct packed {
        logic [3:0]  action;
        logic [1:0]  lane_size;
        logic        is_signed;
        logic        quad;
        logic [63:0] a_low;
        logic [63:0] a_high;
        logic [63:0] b_low;
        logic [63:0] b_high;
        logic [63:0] old_low;
        logic [63:0] old_high;
    } in_beat_t;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } out_beat_t;

    // operand form after stage one: 128-bit wide-lane operands x, y, addend c
    typedef struct packed {
        logic [3:0]   action;
        logic [1:0]   lane_size;
        logic         quad;
        logic         sg;
        logic         bad;
        logic [127:0] x;
        logic [127:0] y;
        logic [127:0] c;
    } opnd_t;

    // wide-lane add of x +/- y + c, per wide lane size (16/32/64)
    function automatic logic [127:0] lane_add(input logic [127:0] x, input logic [127:0] y,
                                              input logic [127:0] c, input logic sub,
                                              input logic [1:0] ls);
        logic [127:0] r;
        logic [127:0] yy;
        r  = '0;
        yy = sub ? ~y : y;
        unique case (ls)
            LS_8: begin
                for (int i = 0; i < 8; i++)
                    r[i*16 +: 16] = x[i*16 +: 16] + yy[i*16 +: 16] + c[i*16 +: 16]
                                    + {15'd0, sub};
            end
            LS_16: begin
                for (int i = 0; i < 4; i++)
                    r[i*32 +: 32] = x[i*32 +: 32] + yy[i*32 +: 32] + c[i*32 +: 32]
                                    + {31'd0, sub};
            end
            default: begin
                for (int i = 0; i < 2; i++)
                    r[i*64 +: 64] = x[i*64 +: 64] + yy[i*64 +: 64] + c[i*64 +: 64]
                                    + {63'd0, sub};
            end
        endcase
        return r;
    endfunction

endpackage

### rtl/slas_prep.sv
// Stage one: extend narrow lanes into wide-lane operands.
module slas_prep (
    input  slas_pkg::in_beat_t i_beat,
    output slas_pkg::opnd_t    o_opnd
);
    import slas_pkg::*;

    logic [255:0] ea;
    logic [255:0] eb;
    logic [127:0] pe;
    logic [127:0] po;
    logic [127:0] rnd;
    logic [127:0] A;
    logic [127:0] B;

    always_comb begin
        A = {i_beat.a_high, i_beat.a_low};
        B = {i_beat.b_high, i_beat.b_low};
        ea = '0; eb = '0; pe = '0; po = '0; rnd = '0;
        unique case (i_beat.lane_size)
            LS_8: begin
                for (int i = 0; i < 16; i++) begin
                    ea[i*16 +: 16] = {{8{i_beat.is_signed & A[i*8+7]}}, A[i*8 +: 8]};
                    eb[i*16 +: 16] = {{8{i_beat.is_signed & B[i*8+7]}}, B[i*8 +: 8]};
                end
                for (int i = 0; i < 8; i++) begin
                    pe[i*16 +: 16] = ea[i*32 +: 16];
                    po[i*16 +: 16] = ea[i*32+16 +: 16];
                    rnd[i*16 +: 16] = 16'h0080;
                end
            end
            LS_16: begin
                for (int i = 0; i < 8; i++) begin
                    ea[i*32 +: 32] = {{16{i_beat.is_signed & A[i*16+15]}}, A[i*16 +: 16]};
                    eb[i*32 +: 32] = {{16{i_beat.is_signed & B[i*16+15]}}, B[i*16 +: 16]};
                end
                for (int i = 0; i < 4; i++) begin
                    pe[i*32 +: 32] = ea[i*64 +: 32];
                    po[i*32 +: 32] = ea[i*64+32 +: 32];
                    rnd[i*32 +: 32] = 32'h0000_8000;
                end
            end
            default: begin
                for (int i = 0; i < 4; i++) begin
                    ea[i*64 +: 64] = {{32{i_beat.is_signed & A[i*32+31]}}, A[i*32 +: 32]};
                    eb[i*64 +: 64] = {{32{i_beat.is_signed & B[i*32+31]}}, B[i*32 +: 32]};
                end
                for (int i = 0; i < 2; i++) begin
                    pe[i*64 +: 64] = ea[i*128 +: 64];
                    po[i*64 +: 64] = ea[i*128+64 +: 64];
                    rnd[i*64 +: 64] = 64'h0000_0000_8000_0000;
                end
            end
        endcase

        o_opnd.action    = i_beat.action;
        o_opnd.lane_size = i_beat.lane_size;
        o_opnd.quad      = i_beat.quad;
        o_opnd.sg        = i_beat.is_signed;
        o_opnd.bad       = (i_beat.lane_size == 2'd3) || (i_beat.action > ACT_PADAL);
        o_opnd.x = '0;
        o_opnd.y = '0;
        o_opnd.c = '0;
        priority case (i_beat.action)
            ACT_ADDL, ACT_SUBL: begin
                o_opnd.x = ea[127:0];
                o_opnd.y = eb[127:0];
            end
            ACT_HADD, ACT_RHADD, ACT_HSUB: begin
                // narrow lanes, extended by one bit in stage two
                o_opnd.x = A;
                o_opnd.y = B;
            end
            ACT_ADDW, ACT_SUBW: begin
                o_opnd.x = A;
                o_opnd.y = eb[127:0];
            end
            ACT_ADDHN, ACT_SUBHN: begin
                o_opnd.x = A;
                o_opnd.y = B;
            end
            ACT_RADDHN, ACT_RSUBHN: begin
                o_opnd.x = A;
                o_opnd.y = B;
                o_opnd.c = rnd;
            end
            ACT_PADD: begin
                // a_low then b_low packed as unextended narrow lanes
                o_opnd.x = {B[63:0], A[63:0]};
                o_opnd.y = '0;
            end
            ACT_PADDL: begin
                o_opnd.x = pe;
                o_opnd.y = po;
            end
            ACT_PADAL: begin
                o_opnd.x = pe;
                o_opnd.y = po;
                o_opnd.c = {i_beat.old_high, i_beat.old_low};
            end
            default: ;
        endcase
    end

endmodule

### rtl/simd_lane_add_sub_unit.sv
// channel | ports            | payload      | handshake
// input   | s_valid, s_ready | s_data (in)  | valid/ready
// result  | m_valid, m_ready | m_data (out) | valid/ready
// Three register stages (extend, lane add, pack/output); one beat per cycle
// sustained while m_ready is high. Synchronous active-low reset clears the
// valid bits only. A stall on m_ready freezes a stage holding a beat only
// when every later stage holds one too; empty stages still fill.
module simd_lane_add_sub_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  slas_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output slas_pkg::out_beat_t m_data
);
    import slas_pkg::*;

    opnd_t        prep_w;
    opnd_t        op1_reg;
    logic         v1_reg, v2_reg, v3_reg;
    logic [3:0]   act2_reg;
    logic [1:0]   ls2_reg;
    logic         quad2_reg, bad2_reg;
    logic [127:0] sum2_reg;
    logic [127:0] psum;
    logic [127:0] hsum;
    out_beat_t    res_next, res_reg;
    logic         en1, en2, en3;
    logic         sub1;
    logic         hc1;
    logic         half1;

    slas_prep u_prep (.i_beat(s_data), .o_opnd(prep_w));

    assign en3 = !v3_reg || m_ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign s_ready = en1;
    assign m_valid = v3_reg;
    assign m_data  = res_reg;

    assign sub1 = (op1_reg.action == ACT_SUBL) || (op1_reg.action == ACT_SUBW)
               || (op1_reg.action == ACT_SUBHN) || (op1_reg.action == ACT_RSUBHN)
               || (op1_reg.action == ACT_HSUB);
    assign hc1  = sub1 || (op1_reg.action == ACT_RHADD);
    assign half1 = (op1_reg.action == ACT_HADD) || (op1_reg.action == ACT_RHADD)
                || (op1_reg.action == ACT_HSUB);

    // padd: narrow pair sums over the packed a_low/b_low word
    always_comb begin
        psum = '0;
        unique case (op1_reg.lane_size)
            LS_8: for (int i = 0; i < 8; i++)
                psum[i*8 +: 8] = op1_reg.x[i*16 +: 8] + op1_reg.x[i*16+8 +: 8];
            LS_16: for (int i = 0; i < 4; i++)
                psum[i*16 +: 16] = op1_reg.x[i*32 +: 16] + op1_reg.x[i*32+16 +: 16];
            default: for (int i = 0; i < 2; i++)
                psum[i*32 +: 32] = op1_reg.x[i*64 +: 32] + op1_reg.x[i*64+32 +: 32];
        endcase
    end

    // halving ops: narrow lane plus one extension bit, keep bits [lw:1]
    always_comb begin
        logic [8:0]  t8;
        logic [16:0] t16;
        logic [32:0] t32;
        hsum = '0;
        t8   = '0;
        t16  = '0;
        t32  = '0;
        unique case (op1_reg.lane_size)
            LS_8: begin
                for (int i = 0; i < 16; i++) begin
                    t8 = {op1_reg.sg & op1_reg.x[i*8+7], op1_reg.x[i*8 +: 8]}
                       + ({op1_reg.sg & op1_reg.y[i*8+7], op1_reg.y[i*8 +: 8]}
                          ^ {9{sub1}})
                       + {8'd0, hc1};
                    hsum[i*8 +: 8] = t8[8:1];
                end
            end
            LS_16: begin
                for (int i = 0; i < 8; i++) begin
                    t16 = {op1_reg.sg & op1_reg.x[i*16+15], op1_reg.x[i*16 +: 16]}
                        + ({op1_reg.sg & op1_reg.y[i*16+15], op1_reg.y[i*16 +: 16]}
                           ^ {17{sub1}})
                        + {16'd0, hc1};
                    hsum[i*16 +: 16] = t16[16:1];
                end
            end
            default: begin
                for (int i = 0; i < 4; i++) begin
                    t32 = {op1_reg.sg & op1_reg.x[i*32+31], op1_reg.x[i*32 +: 32]}
                        + ({op1_reg.sg & op1_reg.y[i*32+31], op1_reg.y[i*32 +: 32]}
                           ^ {33{sub1}})
                        + {32'd0, hc1};
                    hsum[i*32 +: 32] = t32[32:1];
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) op1_reg <= prep_w;
        if (en2) begin
            act2_reg  <= op1_reg.action;
            ls2_reg   <= op1_reg.lane_size;
            quad2_reg <= op1_reg.quad;
            bad2_reg  <= op1_reg.bad;
            sum2_reg  <= (op1_reg.action == ACT_PADD) ? psum
                       : half1 ? hsum
                       : lane_add(op1_reg.x, op1_reg.y, op1_reg.c,
                                  sub1, op1_reg.lane_size);
        end
        if (en3) res_reg <= res_next;
    end

    logic [127:0] s;
    always_comb begin
        s = sum2_reg;
        res_next = '0;
        priority case (act2_reg)
            ACT_ADDL, ACT_SUBL, ACT_ADDW, ACT_SUBW, ACT_PADAL, ACT_PADDL, ACT_PADD,
            ACT_HADD, ACT_RHADD, ACT_HSUB:
                res_next = s;
            ACT_ADDHN, ACT_RADDHN, ACT_SUBHN, ACT_RSUBHN: begin
                unique case (ls2_reg)
                    LS_8: for (int i = 0; i < 8; i++)
                        res_next[i*8 +: 8] = s[i*16+8 +: 8];
                    LS_16: for (int i = 0; i < 4; i++)
                        res_next[i*16 +: 16] = s[i*32+16 +: 16];
                    default: for (int i = 0; i < 2; i++)
                        res_next[i*32 +: 32] = s[i*64+32 +: 32];
                endcase
            end
            default: res_next = '0;
        endcase
        if (!quad2_reg && (act2_reg == ACT_PADDL || act2_reg == ACT_PADAL
                           || act2_reg == ACT_HADD || act2_reg == ACT_RHADD
                           || act2_reg == ACT_HSUB))
            res_next.result_high = '0;
        if (bad2_reg) res_next = '0;
    end

endmodule
